>>> hdl/tcg_pkg.sv
// Shared types, character codes and reply texts of the text command GPIO controller.
`timescale 1ns / 1ps

package tcg_pkg;

  localparam int LINE_MAX_DEF   = 20;
  localparam int PORT_WIDTH_DEF = 16;
  localparam int KEEP_CHARS     = 9;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MSG_IDX_W      = 5;
  localparam int DATA_W         = 16;
  localparam int OUT_TDATA_W    = 72;
  localparam int IN_TDATA_W     = 40;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UI    = 8'h49;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam int LEN_UNKNOWN = 24;
  localparam int LEN_PORT    = 20;
  localparam int LEN_ERROR   = 6;
  localparam int LEN_OK      = 3;
  localparam int LEN_PI      = 5;

  localparam logic [8*LEN_UNKNOWN-1:0] TXT_UNKNOWN = "Instruccion Desconocida\n";
  localparam logic [8*LEN_PORT-1:0]    TXT_PORT    = "Puerto no soportado\n";
  localparam logic [8*LEN_ERROR-1:0]   TXT_ERROR   = "Error\n";
  localparam logic [8*LEN_OK-1:0]      TXT_OK      = "OK\n";
  localparam logic [8*LEN_PI-1:0]      TXT_PI0     = "PI,0\n";
  localparam logic [8*LEN_PI-1:0]      TXT_PI1     = "PI,1\n";

  typedef enum logic [2:0] {
    MSG_UNKNOWN,
    MSG_PORT,
    MSG_ERROR,
    MSG_OK,
    MSG_PI0,
    MSG_PI1
  } msg_e;

  // One reply job: the text to send and the port registers it reports.
  typedef struct packed {
    msg_e              msg;
    logic [DATA_W-1:0] dir_b;
    logic [DATA_W-1:0] dir_c;
    logic [DATA_W-1:0] out_b;
    logic [DATA_W-1:0] out_c;
  } cmd_t;

  function automatic logic [7:0] upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LA && c <= CH_LZ) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // Hex digit value, 16 for anything that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] u;
    logic [4:0] r;
    u = upper(c);
    r = 5'd16;
    if (u >= CH_ZERO && u <= CH_NINE) begin
      r = 5'(u - CH_ZERO);
    end else if (u >= CH_UA && u <= CH_UF) begin
      r = 5'(u - CH_UA) + 5'd10;
    end
    return r;
  endfunction

  function automatic logic [MSG_IDX_W-1:0] msg_len(input msg_e m);
    logic [MSG_IDX_W-1:0] n;
    unique case (m)
      MSG_UNKNOWN: n = MSG_IDX_W'(LEN_UNKNOWN);
      MSG_PORT:    n = MSG_IDX_W'(LEN_PORT);
      MSG_ERROR:   n = MSG_IDX_W'(LEN_ERROR);
      MSG_OK:      n = MSG_IDX_W'(LEN_OK);
      MSG_PI0:     n = MSG_IDX_W'(LEN_PI);
      MSG_PI1:     n = MSG_IDX_W'(LEN_PI);
      default:     n = MSG_IDX_W'(LEN_ERROR);
    endcase
    return n;
  endfunction

  // Text literals keep the first character in the top byte.
  function automatic logic [7:0] msg_char(input msg_e m, input logic [MSG_IDX_W-1:0] idx);
    logic [7:0] ch;
    ch = CH_NUL;
    unique case (m)
      MSG_UNKNOWN: ch = TXT_UNKNOWN[8*(LEN_UNKNOWN-1-int'(idx)) +: 8];
      MSG_PORT:    ch = TXT_PORT[8*(LEN_PORT-1-int'(idx)) +: 8];
      MSG_ERROR:   ch = TXT_ERROR[8*(LEN_ERROR-1-int'(idx)) +: 8];
      MSG_OK:      ch = TXT_OK[8*(LEN_OK-1-int'(idx)) +: 8];
      MSG_PI0:     ch = TXT_PI0[8*(LEN_PI-1-int'(idx)) +: 8];
      MSG_PI1:     ch = TXT_PI1[8*(LEN_PI-1-int'(idx)) +: 8];
      default:     ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

>>> hdl/tcg_front.sv
// Line collector and command decoder; owns the port direction and latch registers.
`timescale 1ns / 1ps

module tcg_front #(
  parameter int LINE_MAX   = tcg_pkg::LINE_MAX_DEF,
  parameter int PORT_WIDTH = tcg_pkg::PORT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 rx_byte_i,
  input  logic [tcg_pkg::DATA_W-1:0] pins_b_i,
  input  logic [tcg_pkg::DATA_W-1:0] pins_c_i,
  input  logic                       full_i,
  output logic                       push_o,
  output tcg_pkg::cmd_t              cmd_o
);

  localparam int CW = $clog2(LINE_MAX);
  localparam logic [CW-1:0] COUNT_LAST = CW'(LINE_MAX - 1);

  logic [CW-1:0]         count_q, count_d;
  logic [7:0]            chars_q [tcg_pkg::KEEP_CHARS];
  logic [7:0]            chars_d [tcg_pkg::KEEP_CHARS];
  logic [PORT_WIDTH-1:0] dir_b_q, dir_b_d, dir_c_q, dir_c_d;
  logic [PORT_WIDTH-1:0] lat_b_q, lat_b_d, lat_c_q, lat_c_d;

  logic [7:0]            ch [tcg_pkg::KEEP_CHARS];
  logic [7:0]            c0, kind, port;
  logic [4:0]            pin;
  logic                  is_b, port_ok, pin_ok, val_ok, val_one, pin_lvl;
  logic [PORT_WIDTH-1:0] mask;
  tcg_pkg::msg_e         line_msg;
  logic                  wr_dir, wr_lat;
  logic                  acc;

  always_comb begin
    for (int k = 0; k < tcg_pkg::KEEP_CHARS; k++) begin
      ch[k] = (count_q > CW'(k)) ? chars_q[k] : tcg_pkg::CH_NUL;
    end
    c0      = tcg_pkg::upper(ch[0]);
    kind    = tcg_pkg::upper(ch[1]);
    port    = tcg_pkg::upper(ch[3]);
    pin     = tcg_pkg::hex_value(ch[5]);
    is_b    = (port == tcg_pkg::CH_UB);
    port_ok = is_b || (port == tcg_pkg::CH_UC);
    pin_ok  = (pin < 5'(PORT_WIDTH));
    val_one = (ch[7] == tcg_pkg::CH_ONE);
    val_ok  = val_one || (ch[7] == tcg_pkg::CH_ZERO);
    pin_lvl = is_b ? pins_b_i[pin[3:0]] : pins_c_i[pin[3:0]];
    for (int i = 0; i < PORT_WIDTH; i++) begin
      mask[i] = (pin == 5'(i));
    end

    // Check in order: command letters, format, port, pin, value.
    line_msg = tcg_pkg::MSG_UNKNOWN;
    wr_dir   = 1'b0;
    wr_lat   = 1'b0;
    if (c0 != tcg_pkg::CH_UP) begin
      line_msg = tcg_pkg::MSG_UNKNOWN;
    end else if (kind == tcg_pkg::CH_UD || kind == tcg_pkg::CH_UO) begin
      if (ch[2] != tcg_pkg::CH_COMMA || ch[4] != tcg_pkg::CH_COMMA ||
          ch[6] != tcg_pkg::CH_COMMA || ch[8] != tcg_pkg::CH_NUL) begin
        line_msg = tcg_pkg::MSG_ERROR;
      end else if (!port_ok) begin
        line_msg = tcg_pkg::MSG_PORT;
      end else if (!pin_ok || !val_ok) begin
        line_msg = tcg_pkg::MSG_ERROR;
      end else begin
        line_msg = tcg_pkg::MSG_OK;
        wr_dir   = (kind == tcg_pkg::CH_UD);
        wr_lat   = (kind == tcg_pkg::CH_UO);
      end
    end else if (kind == tcg_pkg::CH_UI) begin
      if (ch[2] != tcg_pkg::CH_COMMA || ch[4] != tcg_pkg::CH_COMMA ||
          ch[6] != tcg_pkg::CH_NUL) begin
        line_msg = tcg_pkg::MSG_ERROR;
      end else if (!port_ok) begin
        line_msg = tcg_pkg::MSG_PORT;
      end else if (!pin_ok) begin
        line_msg = tcg_pkg::MSG_ERROR;
      end else begin
        line_msg = pin_lvl ? tcg_pkg::MSG_PI1 : tcg_pkg::MSG_PI0;
      end
    end
  end

  assign acc        = in_valid_i && !full_i;
  assign in_ready_o = !full_i;

  always_comb begin
    count_d = count_q;
    chars_d = chars_q;
    dir_b_d = dir_b_q;
    dir_c_d = dir_c_q;
    lat_b_d = lat_b_q;
    lat_c_d = lat_c_q;
    push_o  = 1'b0;
    cmd_o.msg = tcg_pkg::MSG_ERROR;
    if (acc && rx_byte_i != tcg_pkg::CH_NUL) begin
      if (rx_byte_i == tcg_pkg::CH_NL) begin
        push_o    = 1'b1;
        cmd_o.msg = line_msg;
        count_d   = '0;
        if (wr_dir && is_b) begin
          dir_b_d = val_one ? (dir_b_q | mask) : (dir_b_q & ~mask);
        end
        if (wr_dir && !is_b) begin
          dir_c_d = val_one ? (dir_c_q | mask) : (dir_c_q & ~mask);
        end
        if (wr_lat && is_b) begin
          lat_b_d = val_one ? (lat_b_q | mask) : (lat_b_q & ~mask);
        end
        if (wr_lat && !is_b) begin
          lat_c_d = val_one ? (lat_c_q | mask) : (lat_c_q & ~mask);
        end
      end else if (count_q < COUNT_LAST) begin
        for (int k = 0; k < tcg_pkg::KEEP_CHARS; k++) begin
          if (count_q == CW'(k)) begin
            chars_d[k] = rx_byte_i;
          end
        end
        count_d = count_q + CW'(1);
      end else begin
        // Drop the overflowing character and restart the line.
        push_o    = 1'b1;
        cmd_o.msg = tcg_pkg::MSG_ERROR;
        count_d   = '0;
      end
    end
    cmd_o.dir_b = tcg_pkg::DATA_W'(dir_b_d);
    cmd_o.dir_c = tcg_pkg::DATA_W'(dir_c_d);
    cmd_o.out_b = tcg_pkg::DATA_W'(lat_b_d);
    cmd_o.out_c = tcg_pkg::DATA_W'(lat_c_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dir_b_q <= '1;
      dir_c_q <= '1;
      lat_b_q <= '0;
      lat_c_q <= '0;
    end else begin
      count_q <= count_d;
      dir_b_q <= dir_b_d;
      dir_c_q <= dir_c_d;
      lat_b_q <= lat_b_d;
      lat_c_q <= lat_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

>>> hdl/tcg_queue.sv
// Short queue of reply jobs between the decoder and the reply sequencer.
`timescale 1ns / 1ps

module tcg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcg_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output tcg_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);

  tcg_pkg::cmd_t                   mem_q [tcg_pkg::QUEUE_DEPTH];
  logic [tcg_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [tcg_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == tcg_pkg::QUEUE_CNT_W'(tcg_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + tcg_pkg::QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - tcg_pkg::QUEUE_CNT_W'(1);
    end
  end

  // Pointers wrap on their own since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + tcg_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + tcg_pkg::QUEUE_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tcg_pkg::QUEUE_CNT_W'(tcg_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + tcg_pkg::QUEUE_CNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

>>> hdl/tcg_back.sv
// Reply sequencer: spells out each queued reply one character per item.
`timescale 1ns / 1ps

module tcg_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tcg_pkg::cmd_t                      head_i,
  input  logic                               empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tcg_pkg::OUT_TDATA_W-1:0]    out_data_o,
  output logic                               out_last_o
);

  logic                                busy_q, busy_d;
  logic [tcg_pkg::MSG_IDX_W-1:0]       idx_q, idx_d;
  tcg_pkg::cmd_t                       cur_q, cur_d;
  logic                                out_valid_q, out_valid_d;
  logic [tcg_pkg::OUT_TDATA_W-1:0]     out_data_q, out_data_d;
  logic                                out_last_q, out_last_d;
  logic                                slot;
  logic                                is_last;
  logic [7:0]                          cur_char;

  assign slot     = !out_valid_q || out_ready_i;
  assign pop_o    = !busy_q && !empty_i;
  assign cur_char = tcg_pkg::msg_char(cur_q.msg, idx_q);
  assign is_last  = (idx_q == tcg_pkg::msg_len(cur_q.msg) - tcg_pkg::MSG_IDX_W'(1));

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (pop_o) begin
      cur_d  = head_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end
    if (slot) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        out_data_d = {cur_q.out_c, cur_q.out_b, cur_q.dir_c, cur_q.dir_b, cur_char};
        out_last_d = is_last;
        if (is_last) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q + tcg_pkg::MSG_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_idx_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < tcg_pkg::msg_len(cur_q.msg)))
    else $error("character index past end of reply");

  a_mid_reply_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && idx_q != '0) |-> out_valid_q)
    else $error("output register empty in the middle of a reply");

  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_data_q[7:0] == tcg_pkg::CH_NL))
    else $error("reply does not end in a newline");

endmodule

>>> hdl/text_command_gpio_controller_top.sv
// Top level of the text command GPIO controller.
`timescale 1ns / 1ps
//
// Received characters enter on the s_axis channel, one item per character;
// zero bytes are dropped, a newline ends the command line. Each line (and
// each character that overflows the line) yields a text reply on m_axis,
// one character per item, tlast on its final newline. Every reply item
// also carries the direction and output latch bits as they stand after
// the command that caused it.
// The input takes one item per cycle as long as the four-entry reply queue
// has room; a newline is decoded and the port registers updated in the
// cycle it is accepted. Replies go via the queue and the job register to
// the output register, one character per cycle while the receiver is ready,
// idle while the sequencer loads the next job; each is 3 to 24 items long.
// When the receiver stalls, the output register holds its item, replies
// pile up in the queue and s_axis_tready falls once the queue is full.
// Reset empties the line, the queue and the output, sets all direction
// bits (inputs) and clears the output latches.

module text_command_gpio_controller_top #(
  parameter int LINE_MAX   = tcg_pkg::LINE_MAX_DEF,
  parameter int PORT_WIDTH = tcg_pkg::PORT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // rx_byte[7:0], pins_b[23:8], pins_c[39:24]
  input  logic [tcg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tx_byte[7:0], dir_b[23:8], dir_c[39:24], out_b[55:40], out_c[71:56]
  output logic [tcg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);

  tcg_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, full, empty;

  tcg_front #(
    .LINE_MAX  (LINE_MAX),
    .PORT_WIDTH(PORT_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .rx_byte_i (s_axis_tdata[7:0]),
    .pins_b_i  (s_axis_tdata[23:8]),
    .pins_c_i  (s_axis_tdata[39:24]),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  tcg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .full_o (full),
    .empty_o(empty)
  );

  tcg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

>>> tb/tcg_reply_checker.sv
// Reply checker: follows the command line state, predicts each reply and compares the output.
`timescale 1ns / 1ps

module tcg_reply_checker
  import tcg_pkg::*;
#(
  parameter int LINE_MAX   = LINE_MAX_DEF,
  parameter int PORT_WIDTH = PORT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                   m_tlast_i,
  output int                     err_count_o,
  output int                     pending_o,
  output int                     lines_o,
  output int                     chars_o
);

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic [15:0] dir_b;
    logic [15:0] dir_c;
    logic [15:0] out_b;
    logic [15:0] out_c;
  } reply_char_t;

  reply_char_t reply_due[$];
  logic [7:0]  line_buf[KEEP_CHARS];
  logic [4:0]  line_len;
  logic [15:0] dir_b;
  logic [15:0] dir_c;
  logic [15:0] lat_b;
  logic [15:0] lat_c;
  int          errs  = 0;
  int          lines = 0;
  int          chars = 0;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    lines_o     = 0;
    chars_o     = 0;
  end

  function automatic logic [7:0] char_pos(input int k);
    if (k < KEEP_CHARS && k < int'(line_len)) begin
      return line_buf[k];
    end
    return CH_NUL;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_LA && c <= CH_LZ) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  // 16 marks a character that is no hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] u;
    u = fold_case(c);
    if (u >= CH_ZERO && u <= CH_NINE) begin
      return 5'(u - CH_ZERO);
    end
    if (u >= CH_UA && u <= CH_UF) begin
      return 5'(u - CH_UA + 8'd10);
    end
    return 5'd16;
  endfunction

  function automatic string reply_text(input msg_e m);
    case (m)
      MSG_UNKNOWN: return "Instruccion Desconocida\n";
      MSG_PORT:    return "Puerto no soportado\n";
      MSG_OK:      return "OK\n";
      MSG_PI0:     return "PI,0\n";
      MSG_PI1:     return "PI,1\n";
      default:     return "Error\n";
    endcase
  endfunction

  // Decode the held line, apply the port register update and pick the reply.
  function automatic msg_e predict_line(input logic [15:0] pb, input logic [15:0] pc);
    logic [7:0]  kind;
    logic [7:0]  port;
    logic [7:0]  val;
    logic [4:0]  pin;
    logic [15:0] mask;
    logic        level;
    if (fold_case(char_pos(0)) != CH_UP) begin
      return MSG_UNKNOWN;
    end
    kind = fold_case(char_pos(1));
    port = fold_case(char_pos(3));
    pin  = nibble_of(char_pos(5));
    val  = char_pos(7);
    if (kind == CH_UD || kind == CH_UO) begin
      if (char_pos(2) != CH_COMMA || char_pos(4) != CH_COMMA || char_pos(6) != CH_COMMA ||
          char_pos(8) != CH_NUL) begin
        return MSG_ERROR;
      end
      if (port != CH_UB && port != CH_UC) begin
        return MSG_PORT;
      end
      if (int'(pin) >= PORT_WIDTH) begin
        return MSG_ERROR;
      end
      if (val != CH_ZERO && val != CH_ONE) begin
        return MSG_ERROR;
      end
      mask = 16'd1 << pin;
      if (kind == CH_UD) begin
        if (port == CH_UB) begin
          dir_b = (val == CH_ONE) ? (dir_b | mask) : (dir_b & ~mask);
        end else begin
          dir_c = (val == CH_ONE) ? (dir_c | mask) : (dir_c & ~mask);
        end
      end else begin
        if (port == CH_UB) begin
          lat_b = (val == CH_ONE) ? (lat_b | mask) : (lat_b & ~mask);
        end else begin
          lat_c = (val == CH_ONE) ? (lat_c | mask) : (lat_c & ~mask);
        end
      end
      return MSG_OK;
    end
    if (kind == CH_UI) begin
      if (char_pos(2) != CH_COMMA || char_pos(4) != CH_COMMA || char_pos(6) != CH_NUL) begin
        return MSG_ERROR;
      end
      if (port != CH_UB && port != CH_UC) begin
        return MSG_PORT;
      end
      if (int'(pin) >= PORT_WIDTH) begin
        return MSG_ERROR;
      end
      level = (port == CH_UB) ? pb[pin[3:0]] : pc[pin[3:0]];
      return level ? MSG_PI1 : MSG_PI0;
    end
    return MSG_UNKNOWN;
  endfunction

  task automatic queue_reply(input msg_e m);
    string       s;
    reply_char_t r;
    s = reply_text(m);
    for (int k = 0; k < s.len(); k++) begin
      r.ch    = s[k];
      r.last  = (k == s.len() - 1);
      r.dir_b = dir_b;
      r.dir_c = dir_c;
      r.out_b = lat_b;
      r.out_c = lat_c;
      reply_due.push_back(r);
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_char_t want;
    logic [7:0]  c;
    if (!rst_ni) begin
      reply_due.delete();
      foreach (line_buf[k]) line_buf[k] = CH_NUL;
      line_len = '0;
      dir_b    = 16'((1 << PORT_WIDTH) - 1);
      dir_c    = 16'((1 << PORT_WIDTH) - 1);
      lat_b    = '0;
      lat_c    = '0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (reply_due.size() == 0) begin
          errs++;
          $display("%0t: reply item %h arrived with nothing expected", $time, m_tdata_i[7:0]);
        end else begin
          want = reply_due.pop_front();
          check_field("tx_byte", 16'(want.ch), 16'(m_tdata_i[7:0]));
          check_field("last_byte", 16'(want.last), 16'(m_tlast_i));
          check_field("dir_b", want.dir_b, m_tdata_i[23:8]);
          check_field("dir_c", want.dir_c, m_tdata_i[39:24]);
          check_field("out_b", want.out_b, m_tdata_i[55:40]);
          check_field("out_c", want.out_c, m_tdata_i[71:56]);
          chars++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        c = s_tdata_i[7:0];
        if (c == CH_NL) begin
          queue_reply(predict_line(s_tdata_i[23:8], s_tdata_i[39:24]));
          line_len = '0;
          lines++;
        end else if (c != CH_NUL) begin
          if (int'(line_len) < LINE_MAX - 1) begin
            if (int'(line_len) < KEEP_CHARS) begin
              line_buf[line_len] = c;
            end
            line_len = line_len + 5'd1;
          end else begin
            // overflow: drop the character and restart the line
            line_len = '0;
            queue_reply(MSG_ERROR);
          end
        end
      end
    end
    err_count_o <= errs;
    pending_o   <= reply_due.size();
    lines_o     <= lines;
    chars_o     <= chars;
  end

endmodule

>>> tb/text_command_gpio_controller_top_tb.sv
// Testbench top: drives command lines and reply backpressure, and gives the verdict.
`timescale 1ns / 1ps

module text_command_gpio_controller_top_tb;
  import tcg_pkg::*;

  localparam int RAND_ITEMS    = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 300000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int fail_count;
  int pending;
  int lines_seen;
  int chars_checked;
  int items_sent = 0;
  int cycles     = 0;
  bit tx_burst   = 1'b0;
  bit hold_req   = 1'b0;

  text_command_gpio_controller_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  tcg_reply_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .err_count_o (fail_count),
    .pending_o   (pending),
    .lines_o     (lines_seen),
    .chars_o     (chars_checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("text_command_gpio_controller_top_tb: FAIL");
      $finish;
    end
  end

  // Reply side: random stalls per item, burst stretches, and one long hold-off.
  initial begin
    int stall;
    bit rx_burst;
    bit held;
    rx_burst = 1'b0;
    held     = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic [15:0] pb, input logic [15:0] pc);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pc, pb, c};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (c != CH_NUL) items_sent++;
  endtask

  task automatic send_str(input string s, input logic [15:0] pb, input logic [15:0] pc);
    for (int k = 0; k < s.len(); k++) begin
      send_char(s[k], pb, pc);
    end
  endtask

  task automatic send_line(input logic [7:0] q[$]);
    logic [15:0] pb;
    logic [15:0] pc;
    pb = 16'($urandom);
    pc = 16'($urandom);
    foreach (q[k]) send_char(q[k], pb, pc);
  endtask

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if (c >= CH_UA && c <= "Z" && $urandom_range(0, 1) == 1) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  // Mostly well-formed command body, without its newline.
  task automatic make_command(output logic [7:0] q[$]);
    logic [7:0] kind;
    logic [3:0] nib;
    q.delete();
    case ($urandom_range(0, 2))
      0:       kind = CH_UD;
      1:       kind = CH_UO;
      default: kind = CH_UI;
    endcase
    q.push_back(any_case(CH_UP));
    q.push_back(any_case(kind));
    q.push_back(CH_COMMA);
    if ($urandom_range(0, 99) < 85) begin
      q.push_back(any_case($urandom_range(0, 1) ? CH_UB : CH_UC));
    end else begin
      q.push_back(8'($urandom_range(33, 126)));
    end
    q.push_back(CH_COMMA);
    if ($urandom_range(0, 99) < 85) begin
      nib = 4'($urandom_range(0, 15));
      q.push_back(any_case(nib < 4'd10 ? CH_ZERO + 8'(nib) : CH_UA + 8'(nib) - 8'd10));
    end else begin
      q.push_back(8'($urandom_range(33, 126)));
    end
    if (kind != CH_UI) begin
      q.push_back(CH_COMMA);
      if ($urandom_range(0, 99) < 90) begin
        q.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
      end else begin
        q.push_back(8'($urandom_range(33, 126)));
      end
    end
  endtask

  initial begin
    logic [7:0] q[$];
    int         pos;
    int         len;
    int         directed_items;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pin reads at both levels, then every write command on both ports and both values
    send_str("PI,B,0\n", 16'h0000, 16'hFFFF);
    send_str("pi,c,f\n", 16'h0000, 16'hFFFF);
    send_str("PD,B,F,0\n", 16'hFFFF, 16'h0000);
    send_str("pd,c,a,1\n", 16'hFFFF, 16'h0000);
    send_str("PD,c,0,0\n", 16'hFFFF, 16'h0000);
    send_str("PO,B,0,1\n", 16'h0000, 16'h0000);
    send_str("Po,C,F,1\n", 16'h0000, 16'h0000);
    send_str("pO,b,0,0\n", 16'h0000, 16'h0000);
    // empty line, unknown first and second letters
    send_str("\n", 16'h0000, 16'h0000);
    send_str("X\n", 16'h0000, 16'h0000);
    send_str("PX,B,1\n", 16'h0000, 16'h0000);
    // format, port, pin and value errors in checking order
    send_str("PD,B,1\n", 16'h0000, 16'h0000);
    send_str("PD;B,1,1\n", 16'h0000, 16'h0000);
    send_str("PI,B,5,\n", 16'h0000, 16'h0000);
    send_str("PD,E,G,2\n", 16'h0000, 16'h0000);
    send_str("PI,A,3\n", 16'h0000, 16'h0000);
    send_str("PO,B,G,1\n", 16'h0000, 16'h0000);
    send_str("PO,C,3,2\n", 16'h0000, 16'h0000);
    // overflow: the twentieth character yields an error, the rest starts a new line
    send_str("ABCDEFGHIJKLMNOPQRSTUVWXY\n", 16'h0000, 16'h0000);
    // zero bytes inside a line are dropped
    send_str("PI", 16'h0000, 16'h0200);
    send_char(CH_NUL, 16'h0000, 16'h0200);
    send_str(",C,9\n", 16'h0000, 16'h0200);
    directed_items = items_sent;

    // back-to-back reads while the reply side holds off
    hold_req <= 1'b1;
    tx_burst = 1'b1;
    repeat (8) begin
      send_str("PI,B,3\n", 16'($urandom), 16'($urandom));
    end

    while (items_sent - directed_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // raw noise, long enough at times to overflow the line twice
          q.delete();
          len = $urandom_range(0, 44);
          repeat (len) q.push_back(8'($urandom_range(0, 255)));
        end
        2: begin
          make_command(q);
          pos = $urandom_range(0, q.size() - 1);
          case ($urandom_range(0, 2))
            0:       q.delete(pos);
            1:       q.insert(pos, 8'($urandom_range(1, 255)));
            default: q[pos] = 8'($urandom_range(1, 255));
          endcase
        end
        default: make_command(q);
      endcase
      q.push_back(CH_NL);
      send_line(q);
    end
    s_axis_tvalid <= 1'b0;

    // let the last accepted item reach the pending count
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters forming %0d command lines; checked %0d reply characters.",
             items_sent, lines_seen, chars_checked);
    $display("Covered every command and reply kind, line overflow and a %0d-cycle reply stall.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("text_command_gpio_controller_top_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d replies still outstanding", fail_count, pending);
      $display("text_command_gpio_controller_top_tb: FAIL");
    end
    $finish;
  end

endmodule
